@@ src/smf_pkg.sv @@
// Shared types and constants for the symmetric match filter.
package smf_pkg;

    typedef struct packed {
        logic        mode;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [7:0]  match_x;
        logic [7:0]  match_y;
        logic [31:0] match_distance;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } item_t;

    typedef struct packed {
        logic [7:0]  kept_x;
        logic [7:0]  kept_y;
        logic [31:0] kept_distance;
    } result_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int THRESH_W    = 18;
    localparam int DIM_W       = 9;
    localparam int ENTRY_W     = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_SQUARED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_A_MAP_WIDTH       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_A_MAP_HEIGHT      = 2'd2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 18'd16;
    localparam logic [DIM_W-1:0]    DIM_RESET       = 9'd256;
    localparam logic [31:0]         NO_MATCH_DIST   = 32'hFFFF_FFFF;

endpackage

@@ src/smf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module smf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/symmetric_match_filter.sv @@
// A check transaction's result passes through stage 1, stage 2 and the output register; loads give none.
// Throughput: one transaction per cycle; a stalled result freezes the whole pipeline.
// The A-match store is one RAM port pair; a load's write lands before any later read.
// Reset clears pipeline valids and sets threshold 16, map size 256 x 256.
// The store is not cleared: the user must load an entry before it is read; the block does not enforce this.
module symmetric_match_filter #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [smf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [smf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  smf_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output smf_pkg::result_t                    result
);

    import smf_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW     = ($clog2(MAXDIM) + 1 > 9) ? $clog2(MAXDIM) + 1 : 9;
    localparam logic [CW-1:0] MAX_W_C  = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] MAX_H_C  = CW'(MAX_HEIGHT);
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

    // configuration
    logic [THRESH_W-1:0] threshold_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD_SQUARED: threshold_reg <= cfg_data[THRESH_W-1:0];
                CFG_A_MAP_WIDTH:       width_reg     <= cfg_data[DIM_W-1:0];
                CFG_A_MAP_HEIGHT:      height_reg    <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control: everything moves when the output slot frees up
    logic advance;
    logic accept;
    logic result_valid_reg;

    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = advance;
    assign accept     = item_valid && item_ready;

    // stage 0: decode and store access
    logic          load_in_range;
    logic          pre_reject;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [ENTRY_W-1:0] rdata;

    always_comb
    begin
        load_in_range = (CW'(item.pos_x) < MAX_W_C) && (CW'(item.pos_y) < MAX_H_C);
        pre_reject = (item.match_distance == NO_MATCH_DIST)
                  || ((item.red | item.green | item.blue) == 8'd0)
                  || ({1'b0, item.match_x} >= width_reg)
                  || ({1'b0, item.match_y} >= height_reg)
                  || (CW'(item.match_x) >= MAX_W_C)
                  || (CW'(item.match_y) >= MAX_H_C);
        waddr  = AW'(AW'(item.pos_y) * ROW_STEP) + AW'(item.pos_x);
        raddr  = AW'(AW'(item.match_y) * ROW_STEP) + AW'(item.match_x);
        ram_we = accept && (item.mode == MODE_LOAD) && load_in_range;
        ram_re = accept && (item.mode == MODE_CHECK) && !pre_reject;
    end

    smf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata ({item.match_y, item.match_x}),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // stage 1: waiting on the store read
    logic        s1_valid_reg;
    logic        s1_reject_reg;
    logic [7:0]  s1_px_reg;
    logic [7:0]  s1_py_reg;
    logic [7:0]  s1_mx_reg;
    logic [7:0]  s1_my_reg;
    logic [31:0] s1_dist_reg;

    // stage 2: squared displacement terms
    logic        s2_valid_reg;
    logic        s2_reject_reg;
    logic [15:0] s2_dx2_reg;
    logic [15:0] s2_dy2_reg;
    logic [7:0]  s2_mx_reg;
    logic [7:0]  s2_my_reg;
    logic [31:0] s2_dist_reg;

    logic [7:0]  entry_x;
    logic [7:0]  entry_y;
    logic [7:0]  adx;
    logic [7:0]  ady;

    always_comb
    begin
        entry_x = rdata[7:0];
        entry_y = rdata[15:8];
        adx = (s1_px_reg > entry_x) ? s1_px_reg - entry_x : entry_x - s1_px_reg;
        ady = (s1_py_reg > entry_y) ? s1_py_reg - entry_y : entry_y - s1_py_reg;
    end

    // output stage
    logic [16:0] sum_sq;
    logic        keep;
    result_t     result_next;
    result_t     result_reg;

    always_comb
    begin
        sum_sq = {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
        keep   = !s2_reject_reg && (THRESH_W'(sum_sq) < threshold_reg);
        if (keep)
        begin
            result_next.kept_x        = s2_mx_reg;
            result_next.kept_y        = s2_my_reg;
            result_next.kept_distance = s2_dist_reg;
        end
        else
        begin
            result_next.kept_x        = 8'd0;
            result_next.kept_y        = 8'd0;
            result_next.kept_distance = NO_MATCH_DIST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg     <= accept && (item.mode == MODE_CHECK);
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reject_reg <= pre_reject;
            s1_px_reg     <= item.pos_x;
            s1_py_reg     <= item.pos_y;
            s1_mx_reg     <= item.match_x;
            s1_my_reg     <= item.match_y;
            s1_dist_reg   <= item.match_distance;

            s2_reject_reg <= s1_reject_reg;
            s2_dx2_reg    <= {8'd0, adx} * {8'd0, adx};
            s2_dy2_reg    <= {8'd0, ady} * {8'd0, ady};
            s2_mx_reg     <= s1_mx_reg;
            s2_my_reg     <= s1_my_reg;
            s2_dist_reg   <= s1_dist_reg;

            result_reg    <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a store read is only issued for a check that then sits in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> s1_valid_reg)
        else $error("store read without a stage 1 check");

    // at most one transaction per cycle: the store never sees a write and a read together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("store write and read in the same cycle");

    // stage 1 holds its item while the output is stalled, so the read data stays aligned
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("stage 1 dropped an item during a stall");

    // a rejected result carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kept_distance == NO_MATCH_DIST))
            |-> (result.kept_x == 8'd0 && result.kept_y == 8'd0))
        else $error("rejected result with nonzero coordinates");

endmodule
